// ===== sv/qfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package qfa_pkg;

   // Q2.14 components
   localparam int FRAC_BITS = 14;
   localparam int COMP_W    = 16;
   // rounded Hamilton product component, a little headroom over unit length
   localparam int HAM_W     = COMP_W + 2;
   // registers through one Hamilton product unit
   localparam int HAM_LAT   = 3;

   // control that travels beside each item through the pipeline
   typedef struct packed {
      logic valid;
      logic ok;
   } tag_type;

endpackage
`default_nettype wire

// ===== sv/quaternion_forward_align.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Direction | Ports                         | Item
// req      | in        | req_tvalid/tready/tdata       | three quaternions, Q2.14
// rsp      | out       | rsp_tvalid/tready/tdata/tuser | aligned quaternion and ok flag
//
// One item is taken per cycle while req_tready is high; its result passes through
// the normalizer lanes (37 stages, square root and divider one bit per stage
// each), two Hamilton product units (3 stages each), the renormalizer (39
// stages) and the output register.
// Reset is synchronous and only clears the pipeline tags and the output valid bit.
// The pipeline moves whenever the output register is free or its last stage
// holds a bubble; otherwise req_tready drops and everything holds.
module quaternion_forward_align import qfa_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // optical w,x,y,z, capture w,x,y,z, fusion w,x,y,z; 16 bits each
   input  wire logic [191:0]  req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // out_w, out_x, out_y, out_z; 16 bits each
   output logic [63:0]        rsp_tdata,
   // ok
   output logic [0:0]         rsp_tuser
);

   logic                     en;
   logic                     load;
   tag_type                  in_tag;
   logic signed [COMP_W-1:0] opt_q [4];
   logic signed [COMP_W-1:0] cap_q [4];
   logic signed [COMP_W-1:0] fus_q [4];
   tag_type                  opt_tag, cap_tag, fus_tag;
   logic signed [COMP_W-1:0] opt_n [4];
   logic signed [COMP_W-1:0] cap_n [4];
   logic signed [COMP_W-1:0] fus_n [4];
   logic signed [COMP_W-1:0] conj_q [4];
   tag_type                  lanes_tag;
   tag_type                  loc_tag;
   logic signed [HAM_W-1:0]  loc_q [4];
   logic signed [COMP_W-1:0] opt_dly_ff [HAM_LAT][4];
   tag_type                  al_tag;
   logic signed [HAM_W-1:0]  al_q [4];
   tag_type                  fin_tag;
   logic signed [COMP_W-1:0] fin_q [4];
   logic                     rsp_valid_ff;
   logic                     rsp_ok_ff;
   logic signed [COMP_W-1:0] rsp_q_ff [4];

   // pipeline advance
   assign load       = !rsp_valid_ff || rsp_tready;
   assign en         = load || !fin_tag.valid;
   assign req_tready = en;

   assign in_tag.valid = req_tvalid;
   assign in_tag.ok    = 1'b1;

   // unpack input item
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         opt_q[i] = req_tdata[COMP_W*i +: COMP_W];
         cap_q[i] = req_tdata[COMP_W*(4+i) +: COMP_W];
         fus_q[i] = req_tdata[COMP_W*(8+i) +: COMP_W];
      end
   end

   // three normalizer lanes side by side
   qfa_norm #(.IN_W(COMP_W)) u_norm_opt (
      .clock(clock), .reset(reset), .en(en),
      .in_tag(in_tag), .in_q(opt_q), .out_tag(opt_tag), .out_q(opt_n));
   qfa_norm #(.IN_W(COMP_W)) u_norm_cap (
      .clock(clock), .reset(reset), .en(en),
      .in_tag(in_tag), .in_q(cap_q), .out_tag(cap_tag), .out_q(cap_n));
   qfa_norm #(.IN_W(COMP_W)) u_norm_fus (
      .clock(clock), .reset(reset), .en(en),
      .in_tag(in_tag), .in_q(fus_q), .out_tag(fus_tag), .out_q(fus_n));

   // merge lane flags, conjugate the capture orientation
   assign lanes_tag.valid = opt_tag.valid;
   assign lanes_tag.ok    = opt_tag.ok && cap_tag.ok && fus_tag.ok;
   assign conj_q[0] = cap_n[0];
   assign conj_q[1] = -cap_n[1];
   assign conj_q[2] = -cap_n[2];
   assign conj_q[3] = -cap_n[3];

   qfa_hamilton #(.A_W(COMP_W), .B_W(COMP_W)) u_ham_loc (
      .clock(clock), .reset(reset), .en(en),
      .in_tag(lanes_tag), .a_q(conj_q), .b_q(fus_n),
      .out_tag(loc_tag), .out_q(loc_q));

   // optical orientation waits for the first product
   always_ff @(posedge clock) begin
      if (en) begin
         opt_dly_ff[0] <= opt_n;
         for (int k = 1; k < HAM_LAT; k++) opt_dly_ff[k] <= opt_dly_ff[k-1];
      end
   end

   qfa_hamilton #(.A_W(COMP_W), .B_W(HAM_W)) u_ham_al (
      .clock(clock), .reset(reset), .en(en),
      .in_tag(loc_tag), .a_q(opt_dly_ff[HAM_LAT-1]), .b_q(loc_q),
      .out_tag(al_tag), .out_q(al_q));

   // renormalize; a zero product clears ok
   qfa_norm #(.IN_W(HAM_W)) u_norm_al (
      .clock(clock), .reset(reset), .en(en),
      .in_tag(al_tag), .in_q(al_q), .out_tag(fin_tag), .out_q(fin_q));

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= fin_tag.valid;
         rsp_ok_ff    <= fin_tag.ok;
         for (int i = 0; i < 4; i++) begin
            rsp_q_ff[i] <= fin_tag.ok ? fin_q[i] : '0;
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = rsp_ok_ff;
   assign rsp_tdata    = {rsp_q_ff[3], rsp_q_ff[2], rsp_q_ff[1], rsp_q_ff[0]};

endmodule
`default_nettype wire

// ===== sv/qfa_norm.sv =====
`timescale 1ns / 1ps
`default_nettype none
module qfa_norm import qfa_pkg::*; #(
   parameter int IN_W = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire tag_type                  in_tag,
   input  wire logic signed [IN_W-1:0]   in_q [4],
   output tag_type                       out_tag,
   output logic signed [COMP_W-1:0]      out_q [4]
);

   localparam int SUM_W  = 2 * IN_W + 1;
   localparam int ROOT_W = IN_W + 1;
   localparam int Q_W    = FRAC_BITS + 1;
   localparam int NUM_W  = IN_W + FRAC_BITS + 1;
   localparam int REM_W  = ROOT_W + 1;

   // magnitude stage
   tag_type               a_tag_ff;
   logic [IN_W-1:0]       a_mag_ff [4];
   logic [IN_W-1:0]       a_mag_in [4];
   logic [3:0]            a_neg_ff;

   // square stage
   tag_type               b_tag_ff;
   logic [IN_W-1:0]       b_mag_ff [4];
   logic [3:0]            b_neg_ff;
   logic [2*IN_W-1:0]     b_sq_ff [4];

   // root pipeline, entry 0 holds the sum of squares
   tag_type               s_tag_ff  [ROOT_W+1];
   logic [SUM_W:0]        s_rem_ff  [ROOT_W+1];
   logic [ROOT_W-1:0]     s_root_ff [ROOT_W+1];
   logic [IN_W-1:0]       s_mag_ff  [ROOT_W+1][4];
   logic [3:0]            s_neg_ff  [ROOT_W+1];
   logic [SUM_W:0]        sum_in;

   // divider pipeline, entry 0 holds the rounded numerators
   tag_type               d_tag_ff  [Q_W+1];
   logic [ROOT_W-1:0]     d_root_ff [Q_W+1];
   logic [NUM_W-1:0]      d_num_ff  [Q_W+1][4];
   logic [REM_W-1:0]      d_rem_ff  [Q_W+1][4];
   logic [Q_W-1:0]        d_quo_ff  [Q_W+1][4];
   logic [3:0]            d_neg_ff  [Q_W+1];
   logic [NUM_W-1:0]      num_in [4];

   // result stage
   tag_type               o_tag_ff;
   logic signed [COMP_W-1:0] o_q_ff [4];

   // absolute values
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         a_mag_in[i] = in_q[i][IN_W-1] ? IN_W'(-in_q[i]) : IN_W'(in_q[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_tag_ff <= '0;
      end else if (en) begin
         a_tag_ff <= in_tag;
         for (int i = 0; i < 4; i++) begin
            a_mag_ff[i] <= a_mag_in[i];
            a_neg_ff[i] <= in_q[i][IN_W-1];
         end
      end
   end

   // squares; an all-zero quaternion clears ok
   always_ff @(posedge clock) begin
      if (reset) begin
         b_tag_ff <= '0;
      end else if (en) begin
         b_tag_ff.valid <= a_tag_ff.valid;
         b_tag_ff.ok    <= a_tag_ff.ok && ((|a_mag_ff[0]) || (|a_mag_ff[1]) ||
                                           (|a_mag_ff[2]) || (|a_mag_ff[3]));
         b_neg_ff       <= a_neg_ff;
         for (int i = 0; i < 4; i++) begin
            b_mag_ff[i] <= a_mag_ff[i];
            b_sq_ff[i]  <= (2*IN_W)'(a_mag_ff[i]) * (2*IN_W)'(a_mag_ff[i]);
         end
      end
   end

   // sum of squares
   assign sum_in = (SUM_W+1)'(b_sq_ff[0]) + (SUM_W+1)'(b_sq_ff[1]) +
                   (SUM_W+1)'(b_sq_ff[2]) + (SUM_W+1)'(b_sq_ff[3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s_tag_ff[0] <= '0;
      end else if (en) begin
         s_tag_ff[0]  <= b_tag_ff;
         s_rem_ff[0]  <= sum_in;
         s_root_ff[0] <= '0;
         s_neg_ff[0]  <= b_neg_ff;
         for (int i = 0; i < 4; i++) s_mag_ff[0][i] <= b_mag_ff[i];
      end
   end

   // integer square root, one result bit per stage
   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      localparam int BIT = ROOT_W - 1 - k;
      logic [SUM_W:0] trial_in;
      logic           fits_in;

      always_comb begin
         trial_in = ((SUM_W+1)'(s_root_ff[k]) << (BIT + 1)) |
                    ((SUM_W+1)'(1) << (2 * BIT));
         fits_in  = s_rem_ff[k] >= trial_in;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            s_tag_ff[k+1] <= '0;
         end else if (en) begin
            s_tag_ff[k+1]  <= s_tag_ff[k];
            s_neg_ff[k+1]  <= s_neg_ff[k];
            s_rem_ff[k+1]  <= fits_in ? s_rem_ff[k] - trial_in : s_rem_ff[k];
            s_root_ff[k+1] <= fits_in ? (s_root_ff[k] | (ROOT_W'(1) << BIT))
                                      : s_root_ff[k];
            for (int i = 0; i < 4; i++) s_mag_ff[k+1][i] <= s_mag_ff[k][i];
         end
      end
   end

   // numerators with half the divisor added for round to nearest
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         num_in[i] = (NUM_W'(s_mag_ff[ROOT_W][i]) << FRAC_BITS) +
                     NUM_W'(s_root_ff[ROOT_W] >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_tag_ff[0] <= '0;
      end else if (en) begin
         d_tag_ff[0]  <= s_tag_ff[ROOT_W];
         d_root_ff[0] <= s_root_ff[ROOT_W];
         d_neg_ff[0]  <= s_neg_ff[ROOT_W];
         for (int i = 0; i < 4; i++) begin
            d_num_ff[0][i] <= num_in[i];
            d_rem_ff[0][i] <= REM_W'(num_in[i] >> Q_W);
            d_quo_ff[0][i] <= '0;
         end
      end
   end

   // restoring division, one quotient bit per stage for each component
   for (genvar k = 0; k < Q_W; k++) begin : g_div
      localparam int BIT = Q_W - 1 - k;
      logic [REM_W-1:0] part_in [4];
      logic [3:0]       fits_in;

      always_comb begin
         for (int i = 0; i < 4; i++) begin
            part_in[i] = {d_rem_ff[k][i][REM_W-2:0], d_num_ff[k][i][BIT]};
            fits_in[i] = part_in[i] >= REM_W'(d_root_ff[k]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            d_tag_ff[k+1] <= '0;
         end else if (en) begin
            d_tag_ff[k+1]  <= d_tag_ff[k];
            d_root_ff[k+1] <= d_root_ff[k];
            d_neg_ff[k+1]  <= d_neg_ff[k];
            for (int i = 0; i < 4; i++) begin
               d_num_ff[k+1][i] <= d_num_ff[k][i];
               d_rem_ff[k+1][i] <= fits_in[i] ? part_in[i] - REM_W'(d_root_ff[k])
                                              : part_in[i];
               d_quo_ff[k+1][i] <= {d_quo_ff[k][i][Q_W-2:0], fits_in[i]};
            end
         end
      end
   end

   // sign back on
   always_ff @(posedge clock) begin
      if (reset) begin
         o_tag_ff <= '0;
      end else if (en) begin
         o_tag_ff <= d_tag_ff[Q_W];
         for (int i = 0; i < 4; i++) begin
            o_q_ff[i] <= d_neg_ff[Q_W][i] ? -COMP_W'(d_quo_ff[Q_W][i])
                                          : COMP_W'(d_quo_ff[Q_W][i]);
         end
      end
   end

   assign out_tag = o_tag_ff;
   assign out_q   = o_q_ff;

endmodule
`default_nettype wire

// ===== sv/qfa_hamilton.sv =====
`timescale 1ns / 1ps
`default_nettype none
module qfa_hamilton import qfa_pkg::*; #(
   parameter int A_W = 16,
   parameter int B_W = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire tag_type                in_tag,
   input  wire logic signed [A_W-1:0]  a_q [4],
   input  wire logic signed [B_W-1:0]  b_q [4],
   output tag_type                     out_tag,
   output logic signed [HAM_W-1:0]     out_q [4]
);

   localparam int P_W = A_W + B_W;
   localparam int S_W = P_W + 2;

   tag_type                 p_tag_ff;
   logic signed [P_W-1:0]   p_ff [4][4];
   tag_type                 s_tag_ff;
   logic signed [S_W-1:0]   s_ff [4];
   logic signed [S_W-1:0]   s_in [4];
   tag_type                 r_tag_ff;
   logic signed [HAM_W-1:0] r_ff [4];
   logic [S_W-1:0]          mag_in [4];
   logic [S_W-1:0]          rnd_in [4];

   // all sixteen partial products
   always_ff @(posedge clock) begin
      if (reset) begin
         p_tag_ff <= '0;
      end else if (en) begin
         p_tag_ff <= in_tag;
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               p_ff[i][j] <= P_W'(a_q[i]) * P_W'(b_q[j]);
            end
         end
      end
   end

   // Hamilton sums at double fraction width
   always_comb begin
      s_in[0] = S_W'(p_ff[0][0]) - S_W'(p_ff[1][1]) - S_W'(p_ff[2][2]) - S_W'(p_ff[3][3]);
      s_in[1] = S_W'(p_ff[0][1]) + S_W'(p_ff[1][0]) + S_W'(p_ff[2][3]) - S_W'(p_ff[3][2]);
      s_in[2] = S_W'(p_ff[0][2]) - S_W'(p_ff[1][3]) + S_W'(p_ff[2][0]) + S_W'(p_ff[3][1]);
      s_in[3] = S_W'(p_ff[0][3]) + S_W'(p_ff[1][2]) - S_W'(p_ff[2][1]) + S_W'(p_ff[3][0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_tag_ff <= '0;
      end else if (en) begin
         s_tag_ff <= p_tag_ff;
         for (int i = 0; i < 4; i++) s_ff[i] <= s_in[i];
      end
   end

   // round magnitude to nearest, ties away from zero
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         mag_in[i] = s_ff[i][S_W-1] ? S_W'(-s_ff[i]) : S_W'(s_ff[i]);
         rnd_in[i] = (mag_in[i] + (S_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_tag_ff <= '0;
      end else if (en) begin
         r_tag_ff <= s_tag_ff;
         for (int i = 0; i < 4; i++) begin
            r_ff[i] <= s_ff[i][S_W-1] ? -HAM_W'(rnd_in[i]) : HAM_W'(rnd_in[i]);
         end
      end
   end

   assign out_tag = r_tag_ff;
   assign out_q   = r_ff;

endmodule
`default_nettype wire

// ===== tb/quaternion_forward_align_checker.sv =====
`timescale 1ns / 1ps
module quaternion_forward_align_checker import qfa_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [191:0] req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [63:0]  rsp_tdata,
   input  wire logic [0:0]   rsp_tuser,
   output int                errors,
   output int                pending
);

   typedef longint quat_type [4];

   typedef struct {
      logic                     ok;
      logic signed [COMP_W-1:0] comp [4];
   } aligned_type;

   aligned_type aligned_q [$];

   // bitwise integer square root, floor
   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > x) bit_v >>= 2;
      while (bit_v != 0) begin
         if (x >= res + bit_v) begin
            x -= res + bit_v;
            res = (res >> 1) + bit_v;
         end else begin
            res >>= 1;
         end
         bit_v >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned mag(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   // scale to unit length; 0 for the all-zero quaternion
   function automatic bit unit_scale(inout quat_type q);
      longint unsigned sum, r, m, v;
      sum = 0;
      for (int i = 0; i < 4; i++) begin
         m = mag(q[i]);
         sum += m * m;
      end
      if (sum == 0) return 0;
      r = int_sqrt(sum);
      for (int i = 0; i < 4; i++) begin
         m = mag(q[i]);
         v = ((m << FRAC_BITS) + (r >> 1)) / r;
         q[i] = (q[i] < 0) ? -longint'(v) : longint'(v);
      end
      return 1;
   endfunction

   // drop FRAC_BITS, nearest with ties away from zero
   function automatic longint round_frac(longint s);
      longint unsigned v;
      v = (mag(s) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return (s < 0) ? -longint'(v) : longint'(v);
   endfunction

   function automatic void hamilton(input quat_type a, input quat_type b, output quat_type r);
      r[0] = round_frac(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]);
      r[1] = round_frac(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2]);
      r[2] = round_frac(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1]);
      r[3] = round_frac(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0]);
   endfunction

   function automatic aligned_type forward_align(logic [191:0] d);
      quat_type opt, cap, fus, delta, al;
      aligned_type e;
      bit ok;
      for (int i = 0; i < 4; i++) begin
         opt[i] = longint'($signed(d[16*i +: 16]));
         cap[i] = longint'($signed(d[64 + 16*i +: 16]));
         fus[i] = longint'($signed(d[128 + 16*i +: 16]));
      end
      ok = unit_scale(opt);
      ok = unit_scale(cap) && ok;
      ok = unit_scale(fus) && ok;
      if (ok) begin
         for (int i = 1; i < 4; i++) cap[i] = -cap[i];
         hamilton(cap, fus, delta);
         hamilton(opt, delta, al);
         ok = unit_scale(al);
      end
      e.ok = ok;
      for (int i = 0; i < 4; i++) e.comp[i] = ok ? al[i][COMP_W-1:0] : '0;
      return e;
   endfunction

   assign pending = aligned_q.size();

   // predict on accepted input items
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) aligned_q.push_back(forward_align(req_tdata));
   end

   // compare accepted results with the oldest prediction
   initial errors = 0;
   always @(posedge clock) begin
      aligned_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (aligned_q.size() == 0) begin
            $error("result item with no prediction waiting");
            errors++;
         end else begin
            e = aligned_q.pop_front();
            if (rsp_tuser[0] !== e.ok) begin
               $error("ok: expected %0d, actual %0d", e.ok, rsp_tuser[0]);
               errors++;
            end
            for (int i = 0; i < 4; i++) begin
               if (rsp_tdata[16*i +: 16] !== e.comp[i]) begin
                  $error("out_%s: expected %0d, actual %0d", i == 0 ? "w" : i == 1 ? "x" :
                         i == 2 ? "y" : "z", e.comp[i], $signed(rsp_tdata[16*i +: 16]));
                  errors++;
               end
            end
         end
      end
   end

endmodule

// ===== tb/quaternion_forward_align_tb.sv =====
`timescale 1ns / 1ps
module quaternion_forward_align_tb;
   import qfa_pkg::*;

   localparam int ITEMS_PER_PHASE = 480;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int DRAIN_CYCLES    = 300;
   localparam int HOLD_CYCLES     = 400;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [191:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   int           errors;
   int           pending;
   int           send_idle_pct;
   int           recv_stall_pct;
   bit           hold_go;
   int           hold_cnt;
   int           cycles;

   quaternion_forward_align u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   quaternion_forward_align_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .errors(errors), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // watchdog
   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("quaternion_forward_align test failed");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      rsp_tready = 0;
      hold_cnt = 0;
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go = 0;
            hold_cnt = HOLD_CYCLES;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // one component: mostly full range, some extremes and small values
   function automatic logic [15:0] rand_comp();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($signed($urandom_range(8)) - 4);
         3: return 16'd16384;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [63:0] rand_quat();
      logic [63:0] q;
      case ($urandom_range(19))
         0: q = '0;
         1: q = {48'd0, 16'($urandom_range(1, 65535))};
         default: for (int i = 0; i < 4; i++) q[16*i +: 16] = rand_comp();
      endcase
      return q;
   endfunction

   // offer one item at a posedge, return at the posedge that accepts it
   task automatic send_item(logic [191:0] d);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      forever begin
         @(negedge clock);
         if (req_tready) break;
         @(posedge clock);
      end
      @(posedge clock);
   endtask

   task automatic send_quats(logic [63:0] o, logic [63:0] c, logic [63:0] f);
      send_item({f, c, o});
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      logic [63:0] ident, tilt;
      req_tvalid = 0;
      req_tdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_go = 0;
      reset = 1;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: zero inputs in each slot, identity, extremes
      ident = {48'd0, 16'd16384};
      tilt  = {16'd0, 16'd0, 16'd11585, 16'd11585};
      send_quats(ident, ident, ident);
      send_quats('0, ident, ident);
      send_quats(ident, '0, ident);
      send_quats(ident, ident, '0);
      send_quats('0, '0, '0);
      send_quats({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
      send_quats({4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}});
      send_quats({4{16'h7fff}}, {4{16'h8000}}, {4{16'hffff}});
      send_quats({48'd0, 16'd1}, {48'd0, 16'hffff}, {16'd1, 48'd0});
      send_quats(tilt, ident, tilt);
      send_quats(ident, tilt, ident);
      send_quats({16'h8000, 48'd0}, {32'd0, 16'h7fff, 16'd0}, {16'd0, 16'h8000, 32'd0});
      send_quats({4{16'hffff}}, {4{16'h0001}}, {4{16'hfffe}});
      send_quats({4{16'h5555}}, {4{16'haaaa}}, {4{16'h0101}});
      wait_drained();

      // random phases: free flow, sender gaps, receiver stalls, both
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 25 : 54) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 25 : 54) : 0;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // long receiver hold-off while items keep coming
            if (ph == 0 && n == 100) hold_go = 1;
            // a pause until everything has come out
            if (n == 240) wait_drained();
            send_quats(rand_quat(), rand_quat(), rand_quat());
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("quaternion_forward_align test passed");
      end else begin
         $display("quaternion_forward_align test failed");
      end
      $finish;
   end

endmodule

// ===== quaternion_forward_align.f =====
sv/qfa_pkg.sv
sv/qfa_norm.sv
sv/qfa_hamilton.sv
sv/quaternion_forward_align.sv
tb/quaternion_forward_align_checker.sv
tb/quaternion_forward_align_tb.sv
